// ----- hdl/rtfh_pkg.sv -----
package rtfh_pkg;

  localparam int FRAC_BITS = 16;
  localparam int EPS_SHIFT = 3 * FRAC_BITS - 23;

  localparam int W_COORD = 32;
  localparam int W_E     = W_COORD + 1;
  localparam int W_R     = 2 * W_COORD + 2;
  localparam int W_Q     = 2 * W_E + 1;
  localparam int W_D     = W_Q + W_E + 1;
  localparam int W_UV    = W_D + 1;
  localparam int W_NUM   = W_D + FRAC_BITS - 1;
  localparam int W_T     = 64;
  localparam int W_ACC   = W_D + 3;
  localparam int W_B     = W_E;

  localparam int MAC_CNT_W = $clog2(W_B);
  localparam int DIV_CNT_W = $clog2(W_NUM);

  localparam int W_CFG_IDX = 3;
  localparam logic [W_CFG_IDX-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [W_CFG_IDX-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [W_CFG_IDX-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [W_CFG_IDX-1:0] CFG_DIR_X    = 3'd3;
  localparam logic [W_CFG_IDX-1:0] CFG_DIR_Y    = 3'd4;
  localparam logic [W_CFG_IDX-1:0] CFG_DIR_Z    = 3'd5;
  localparam logic [W_CFG_IDX-1:0] CFG_BACKFACE = 3'd6;

  localparam logic signed [W_COORD-1:0] DIR_Z_RESET = W_COORD'(1 << FRAC_BITS);
  localparam logic signed [W_COORD-1:0] HIT_MIN = {1'b1, {(W_COORD-1){1'b0}}};
  localparam logic signed [W_COORD-1:0] HIT_MAX = {1'b0, {(W_COORD-1){1'b1}}};

  typedef struct packed {
    logic start;
    logic clear;
    logic neg;
  } mac_cmd_t;

endpackage

// ----- hdl/rtfh_mac.sv -----
module rtfh_mac (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rtfh_pkg::mac_cmd_t                   cmd,
  input  logic signed [rtfh_pkg::W_ACC-1:0]    op_a,
  input  logic signed [rtfh_pkg::W_B-1:0]      op_b,
  output logic signed [rtfh_pkg::W_ACC-1:0]    acc,
  output logic                                 done
);
  import rtfh_pkg::*;

  logic signed [W_ACC-1:0]   a_r;
  logic signed [W_B-1:0]     b_r;
  logic signed [W_ACC-1:0]   acc_r;
  logic [MAC_CNT_W-1:0]      cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic                      neg_r;
  logic                      sub;

  // top bit of the multiplier has negative weight
  assign sub  = neg_r ^ (cnt_r == MAC_CNT_W'(W_B - 1));
  assign acc  = acc_r;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        a_r    <= op_a;
        b_r    <= op_b;
        neg_r  <= cmd.neg;
        cnt_r  <= '0;
        busy_r <= 1'b1;
        if (cmd.clear) begin
          acc_r <= '0;
        end
      end else if (busy_r) begin
        if (b_r[0]) begin
          acc_r <= sub ? acc_r - a_r : acc_r + a_r;
        end
        a_r   <= a_r <<< 1;
        b_r   <= b_r >>> 1;
        cnt_r <= cnt_r + MAC_CNT_W'(1);
        if (cnt_r == MAC_CNT_W'(W_B - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/rtfh_div.sv -----
module rtfh_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [rtfh_pkg::W_NUM-1:0]     num,
  input  logic [rtfh_pkg::W_D-1:0]       den,
  output logic [rtfh_pkg::W_NUM-1:0]     quo,
  output logic                           done
);
  import rtfh_pkg::*;

  logic [W_NUM-1:0]      n_r;
  logic [W_NUM-1:0]      q_r;
  logic [W_D-1:0]        den_r;
  logic [W_D-1:0]        rem_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [W_D:0]          rem_sh;
  logic                  fits;

  assign rem_sh = {rem_r, n_r[W_NUM-1]};
  assign fits   = rem_sh >= {1'b0, den_r};
  assign quo    = q_r;
  assign done   = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        n_r    <= num;
        den_r  <= den;
        rem_r  <= '0;
        q_r    <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? W_D'(rem_sh - {1'b0, den_r}) : W_D'(rem_sh);
        q_r   <= {q_r[W_NUM-2:0], fits};
        n_r   <= n_r << 1;
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(W_NUM - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/ray_triangle_first_hit_core.sv -----
// a missed triangle needs 21 products and a hit needs 27, all on one shift-add unit
// a hit also runs the divider, which yields a 116-bit quotient
// triangles after a hit are skipped up to and including the last one; one triangle in flight at a time
// the result register lets the next item start while a result waits
// reset: synchronous active-low rst_n; state, configuration and valid flags are reset, datapath registers are not
module ray_triangle_first_hit_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [rtfh_pkg::W_CFG_IDX-1:0]        cfg_index,
  input  logic [rtfh_pkg::W_COORD-1:0]          cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [rtfh_pkg::W_COORD-1:0]   in_vert0_x,
  input  logic signed [rtfh_pkg::W_COORD-1:0]   in_vert0_y,
  input  logic signed [rtfh_pkg::W_COORD-1:0]   in_vert0_z,
  input  logic signed [rtfh_pkg::W_COORD-1:0]   in_vert1_x,
  input  logic signed [rtfh_pkg::W_COORD-1:0]   in_vert1_y,
  input  logic signed [rtfh_pkg::W_COORD-1:0]   in_vert1_z,
  input  logic signed [rtfh_pkg::W_COORD-1:0]   in_vert2_x,
  input  logic signed [rtfh_pkg::W_COORD-1:0]   in_vert2_y,
  input  logic signed [rtfh_pkg::W_COORD-1:0]   in_vert2_z,
  input  logic                                  in_last_triangle,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_hit_found,
  output logic signed [rtfh_pkg::W_COORD-1:0]   out_hit_x,
  output logic signed [rtfh_pkg::W_COORD-1:0]   out_hit_y,
  output logic signed [rtfh_pkg::W_COORD-1:0]   out_hit_z
);
  import rtfh_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_DECIDE, ST_DIV_GO, ST_DIV_WAIT, ST_FINISH
  } state_t;

  typedef enum logic [4:0] {
    OP_RX0, OP_RX1, OP_RY0, OP_RY1, OP_RZ0, OP_RZ1,
    OP_QX0, OP_QX1, OP_QY0, OP_QY1, OP_QZ0, OP_QZ1,
    OP_UX, OP_UY, OP_UZ, OP_AX, OP_AY, OP_AZ, OP_VX, OP_VY, OP_VZ,
    OP_EX, OP_EY, OP_EZ, OP_HX, OP_HY, OP_HZ
  } op_t;

  localparam logic signed [W_D-1:0] EPS_POS = W_D'(1) <<< EPS_SHIFT;
  localparam logic signed [W_D-1:0] EPS_NEG = -EPS_POS;
  localparam logic [W_NUM-1:0]      T_MAX   = W_NUM'(1) << (W_T - 2);

  state_t state_r;
  op_t    op_r;

  logic signed [W_COORD-1:0] orig_r [3];
  logic signed [W_COORD-1:0] dir_r [3];
  logic                      bfe_r;
  logic                      already_hit_r;
  logic                      last_r;
  logic                      neg_t_r;

  logic signed [W_E-1:0]     e1_r [3];
  logic signed [W_E-1:0]     e2_r [3];
  logic signed [W_E-1:0]     s_r [3];
  logic signed [W_R-1:0]     r_r [3];
  logic signed [W_Q-1:0]     q_r [3];
  logic signed [W_D-1:0]     u_r;
  logic signed [W_D-1:0]     a_r;
  logic signed [W_D-1:0]     v_r;
  logic signed [W_D-1:0]     e2q_r;
  logic signed [W_T-1:0]     t_r;
  logic signed [W_COORD-1:0] hit_r [3];
  logic                      found_r;

  logic                      out_valid_r;
  logic                      out_found_r;
  logic signed [W_COORD-1:0] out_x_r;
  logic signed [W_COORD-1:0] out_y_r;
  logic signed [W_COORD-1:0] out_z_r;

  mac_cmd_t                  mac_cmd;
  logic signed [W_ACC-1:0]   mac_a;
  logic signed [W_B-1:0]     mac_b;
  logic signed [W_ACC-1:0]   mac_acc;
  logic                      mac_done;

  logic                      div_start;
  logic [W_NUM-1:0]          div_num;
  logic [W_D-1:0]            div_den;
  logic [W_NUM-1:0]          div_quo;
  logic                      div_done;

  logic                      in_accept;
  logic                      out_free;
  logic signed [W_COORD-1:0] hit_orig;
  logic signed [W_ACC-1:0]   hit_shift;
  logic signed [W_ACC-1:0]   hit_sum;
  logic signed [W_COORD-1:0] hit_sat;
  logic signed [W_UV-1:0]    uv;
  logic                      front_ok;
  logic                      back_ok;
  logic                      tri_hit;
  logic [W_D-1:0]            e2q_abs;
  logic [W_NUM-1:0]          t_mag;
  logic signed [W_T-1:0]     t_pos;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_hit_found = out_found_r;
  assign out_hit_x     = out_x_r;
  assign out_hit_y     = out_y_r;
  assign out_hit_z     = out_z_r;

  // operand selection for the shared multiply-accumulate unit
  always_comb begin
    mac_a       = '0;
    mac_b       = '0;
    mac_cmd.start = (state_r == ST_MUL_GO);
    mac_cmd.clear = 1'b0;
    mac_cmd.neg   = 1'b0;
    hit_orig    = '0;
    unique case (op_r)
      OP_RX0: begin mac_a = W_ACC'(e2_r[2]); mac_b = W_B'(dir_r[1]); mac_cmd.clear = 1'b1; end
      OP_RX1: begin mac_a = W_ACC'(e2_r[1]); mac_b = W_B'(dir_r[2]); mac_cmd.neg = 1'b1; end
      OP_RY0: begin mac_a = W_ACC'(e2_r[0]); mac_b = W_B'(dir_r[2]); mac_cmd.clear = 1'b1; end
      OP_RY1: begin mac_a = W_ACC'(e2_r[2]); mac_b = W_B'(dir_r[0]); mac_cmd.neg = 1'b1; end
      OP_RZ0: begin mac_a = W_ACC'(e2_r[1]); mac_b = W_B'(dir_r[0]); mac_cmd.clear = 1'b1; end
      OP_RZ1: begin mac_a = W_ACC'(e2_r[0]); mac_b = W_B'(dir_r[1]); mac_cmd.neg = 1'b1; end
      OP_QX0: begin mac_a = W_ACC'(e1_r[2]); mac_b = s_r[1]; mac_cmd.clear = 1'b1; end
      OP_QX1: begin mac_a = W_ACC'(e1_r[1]); mac_b = s_r[2]; mac_cmd.neg = 1'b1; end
      OP_QY0: begin mac_a = W_ACC'(e1_r[0]); mac_b = s_r[2]; mac_cmd.clear = 1'b1; end
      OP_QY1: begin mac_a = W_ACC'(e1_r[2]); mac_b = s_r[0]; mac_cmd.neg = 1'b1; end
      OP_QZ0: begin mac_a = W_ACC'(e1_r[1]); mac_b = s_r[0]; mac_cmd.clear = 1'b1; end
      OP_QZ1: begin mac_a = W_ACC'(e1_r[0]); mac_b = s_r[1]; mac_cmd.neg = 1'b1; end
      OP_UX:  begin mac_a = W_ACC'(r_r[0]); mac_b = s_r[0]; mac_cmd.clear = 1'b1; end
      OP_UY:  begin mac_a = W_ACC'(r_r[1]); mac_b = s_r[1]; end
      OP_UZ:  begin mac_a = W_ACC'(r_r[2]); mac_b = s_r[2]; end
      OP_AX:  begin mac_a = W_ACC'(r_r[0]); mac_b = e1_r[0]; mac_cmd.clear = 1'b1; end
      OP_AY:  begin mac_a = W_ACC'(r_r[1]); mac_b = e1_r[1]; end
      OP_AZ:  begin mac_a = W_ACC'(r_r[2]); mac_b = e1_r[2]; end
      OP_VX:  begin mac_a = W_ACC'(q_r[0]); mac_b = W_B'(dir_r[0]); mac_cmd.clear = 1'b1; end
      OP_VY:  begin mac_a = W_ACC'(q_r[1]); mac_b = W_B'(dir_r[1]); end
      OP_VZ:  begin mac_a = W_ACC'(q_r[2]); mac_b = W_B'(dir_r[2]); end
      OP_EX:  begin mac_a = W_ACC'(q_r[0]); mac_b = e2_r[0]; mac_cmd.clear = 1'b1; end
      OP_EY:  begin mac_a = W_ACC'(q_r[1]); mac_b = e2_r[1]; end
      OP_EZ:  begin mac_a = W_ACC'(q_r[2]); mac_b = e2_r[2]; end
      OP_HX:  begin
        mac_a = W_ACC'(t_r); mac_b = W_B'(dir_r[0]); mac_cmd.clear = 1'b1;
        hit_orig = orig_r[0];
      end
      OP_HY:  begin
        mac_a = W_ACC'(t_r); mac_b = W_B'(dir_r[1]); mac_cmd.clear = 1'b1;
        hit_orig = orig_r[1];
      end
      OP_HZ:  begin
        mac_a = W_ACC'(t_r); mac_b = W_B'(dir_r[2]); mac_cmd.clear = 1'b1;
        hit_orig = orig_r[2];
      end
      default: begin mac_a = '0; end
    endcase
  end

  // hit point: origin plus floor(dir * t) in fixed point, saturated
  always_comb begin
    hit_shift = mac_acc >>> FRAC_BITS;
    hit_sum   = hit_shift + W_ACC'(hit_orig);
    if (hit_sum < W_ACC'(HIT_MIN)) begin
      hit_sat = HIT_MIN;
    end else if (hit_sum > W_ACC'(HIT_MAX)) begin
      hit_sat = HIT_MAX;
    end else begin
      hit_sat = W_COORD'(hit_sum);
    end
  end

  // face tests on the determinant and the barycentric numerators
  always_comb begin
    uv       = W_UV'(u_r) + W_UV'(v_r);
    front_ok = (a_r > EPS_POS) && !(u_r < 0 || u_r > a_r || v_r < 0 || uv > W_UV'(a_r));
    back_ok  = bfe_r && (a_r < EPS_NEG)
               && !(u_r > 0 || u_r < a_r || v_r > 0 || uv < W_UV'(a_r));
    tri_hit  = front_ok || back_ok;
  end

  assign e2q_abs   = e2q_r[W_D-1] ? W_D'(-e2q_r) : W_D'(e2q_r);
  assign div_num   = {e2q_abs[W_D-2:0], {FRAC_BITS{1'b0}}};
  assign div_den   = a_r[W_D-1] ? W_D'(-a_r) : W_D'(a_r);
  assign div_start = (state_r == ST_DIV_GO);
  assign t_mag     = (div_quo > T_MAX) ? T_MAX : div_quo;
  assign t_pos     = W_T'(t_mag);

  rtfh_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mac_cmd),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .acc   (mac_acc),
    .done  (mac_done)
  );

  rtfh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      op_r          <= OP_RX0;
      orig_r[0]     <= '0;
      orig_r[1]     <= '0;
      orig_r[2]     <= '0;
      dir_r[0]      <= '0;
      dir_r[1]      <= '0;
      dir_r[2]      <= DIR_Z_RESET;
      bfe_r         <= 1'b1;
      already_hit_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ORIGIN_X: orig_r[0] <= cfg_data;
          CFG_ORIGIN_Y: orig_r[1] <= cfg_data;
          CFG_ORIGIN_Z: orig_r[2] <= cfg_data;
          CFG_DIR_X:    dir_r[0]  <= cfg_data;
          CFG_DIR_Y:    dir_r[1]  <= cfg_data;
          CFG_DIR_Z:    dir_r[2]  <= cfg_data;
          CFG_BACKFACE: bfe_r     <= cfg_data[0];
          default:      bfe_r     <= bfe_r;
        endcase
      end

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            if (already_hit_r) begin
              if (in_last_triangle) begin
                already_hit_r <= 1'b0;
              end
            end else begin
              e1_r[0] <= W_E'(in_vert1_x) - W_E'(in_vert0_x);
              e1_r[1] <= W_E'(in_vert1_y) - W_E'(in_vert0_y);
              e1_r[2] <= W_E'(in_vert1_z) - W_E'(in_vert0_z);
              e2_r[0] <= W_E'(in_vert2_x) - W_E'(in_vert0_x);
              e2_r[1] <= W_E'(in_vert2_y) - W_E'(in_vert0_y);
              e2_r[2] <= W_E'(in_vert2_z) - W_E'(in_vert0_z);
              s_r[0]  <= W_E'(orig_r[0]) - W_E'(in_vert0_x);
              s_r[1]  <= W_E'(orig_r[1]) - W_E'(in_vert0_y);
              s_r[2]  <= W_E'(orig_r[2]) - W_E'(in_vert0_z);
              last_r  <= in_last_triangle;
              op_r    <= OP_RX0;
              state_r <= ST_MUL_GO;
            end
          end
        end
        ST_MUL_GO: begin
          state_r <= ST_MUL_WAIT;
        end
        ST_MUL_WAIT: begin
          if (mac_done) begin
            unique case (op_r)
              OP_RX1: r_r[0] <= W_R'(mac_acc);
              OP_RY1: r_r[1] <= W_R'(mac_acc);
              OP_RZ1: r_r[2] <= W_R'(mac_acc);
              OP_QX1: q_r[0] <= W_Q'(mac_acc);
              OP_QY1: q_r[1] <= W_Q'(mac_acc);
              OP_QZ1: q_r[2] <= W_Q'(mac_acc);
              OP_UZ:  u_r    <= W_D'(mac_acc);
              OP_AZ:  a_r    <= W_D'(mac_acc);
              OP_VZ:  v_r    <= W_D'(mac_acc);
              OP_EZ:  e2q_r  <= W_D'(mac_acc);
              OP_HX:  hit_r[0] <= hit_sat;
              OP_HY:  hit_r[1] <= hit_sat;
              OP_HZ:  hit_r[2] <= hit_sat;
              default: hit_r[0] <= hit_r[0];
            endcase
            priority if (op_r == OP_VZ) begin
              state_r <= ST_DECIDE;
            end else if (op_r == OP_EZ) begin
              state_r <= ST_DIV_GO;
            end else if (op_r == OP_HZ) begin
              found_r <= 1'b1;
              state_r <= ST_FINISH;
            end else begin
              op_r    <= op_t'(op_r + 5'd1);
              state_r <= ST_MUL_GO;
            end
          end
        end
        ST_DECIDE: begin
          neg_t_r <= e2q_r[W_D-1] ^ a_r[W_D-1];
          priority if (tri_hit) begin
            op_r    <= OP_EX;
            state_r <= ST_MUL_GO;
          end else if (last_r) begin
            found_r <= 1'b0;
            state_r <= ST_FINISH;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_DIV_GO: begin
          neg_t_r <= e2q_r[W_D-1] ^ a_r[W_D-1];
          state_r <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            t_r     <= neg_t_r ? -t_pos : t_pos;
            op_r    <= OP_HX;
            state_r <= ST_MUL_GO;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_found_r <= found_r;
            out_x_r     <= found_r ? hit_r[0] : '0;
            out_y_r     <= found_r ? hit_r[1] : '0;
            out_z_r     <= found_r ? hit_r[2] : '0;
            if (found_r) begin
              already_hit_r <= !last_r;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/rtfh_checker.sv -----
module rtfh_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic                                  out_hit_found,
  input logic signed [rtfh_pkg::W_COORD-1:0]   out_hit_x,
  input logic signed [rtfh_pkg::W_COORD-1:0]   out_hit_y,
  input logic signed [rtfh_pkg::W_COORD-1:0]   out_hit_z
);
  import rtfh_pkg::*;

  // a no-hit item carries a zero point
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit_found |-> out_hit_x == 0 && out_hit_y == 0 && out_hit_z == 0)
    else $error("no-hit item with nonzero point");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // reset leaves the block ready for an item
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit_found)
      && $stable(out_hit_x) && $stable(out_hit_y) && $stable(out_hit_z))
    else $error("stalled result changed");

endmodule

bind ray_triangle_first_hit_core rtfh_checker u_rtfh_checker (.*);
